[rtl/mmfs_pkg.sv]
// ----------------------------------------------------------------------------
// Min-max feature scaler package
// Widths, command and status codes, and the control structs shared between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package mmfs_pkg;

   localparam int NUM_COLUMNS = 64;
   localparam int COLUMN_W    = 6;
   localparam int COL_IDX_W   = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
   localparam int DATA_W      = 32;
   localparam int SCALED_W    = 17;
   localparam int FRAC_W      = 16;

   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_OBSERVE = 2'd0;
   localparam cmd_type CMD_SCALE   = 2'd1;
   localparam cmd_type CMD_CLEAR   = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK         = 2'd0;
   localparam status_type ST_ZERO_RANGE = 2'd1;
   localparam status_type ST_CLAMPED    = 2'd2;
   localparam status_type ST_UNSEEN     = 2'd3;

   localparam logic [SCALED_W-1:0] Q_ONE = SCALED_W'(1 << FRAC_W);

   typedef struct packed {
      logic load_item;
      logic obs_write;
      logic seen_clear;
      logic diff_load;
      logic check_load;
      logic div_start;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    early_result;
      logic    div_done;
      logic    out_free;
   } dp_status_type;

endpackage

[rtl/mmfs_if.sv]
// ----------------------------------------------------------------------------
// Min-max feature scaler channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mmfs_req_if import mmfs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   cmd_type                  cmd;
   logic [COLUMN_W-1:0]      column;
   logic signed [DATA_W-1:0] sample_value;

   modport source (output valid, output cmd, output column, output sample_value,
                   input ready);
   modport sink   (input valid, input cmd, input column, input sample_value,
                   output ready);
endinterface

interface mmfs_rsp_if import mmfs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SCALED_W-1:0] scaled_value;
   status_type          status;

   modport source (output valid, output scaled_value, output status, input ready);
   modport sink   (input valid, input scaled_value, input status, output ready);
endinterface

[rtl/mmfs_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mmfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

[rtl/mmfs_divider.sv]
// ----------------------------------------------------------------------------
// Radix-2 restoring divider
// Gives floor(dividend * 2^16 / divisor) for dividend <= divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmfs_divider import mmfs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DATA_W-1:0]   dividend,
   input  logic [DATA_W-1:0]   divisor,
   output logic [SCALED_W-1:0] quotient,
   output logic                done
);

   localparam int CNT_W = $clog2(SCALED_W + 1);

   logic [CNT_W-1:0]    count_ff;
   logic [DATA_W-1:0]   rem_ff;
   logic [SCALED_W-1:0] quo_ff;
   logic                first_ff;
   logic [DATA_W:0]     trial;
   logic [DATA_W+1:0]   diff;
   logic                take;
   logic                busy;

   // The first step tests the integer bit without a shift; the remainder
   // stays below the divisor afterwards, so it always fits the data width.
   assign trial = first_ff ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign diff  = {1'b0, trial} - {2'b00, divisor};
   assign take  = ~diff[DATA_W+1];
   assign busy  = (count_ff != '0);
   assign done  = (count_ff == CNT_W'(1));
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (start) begin
         count_ff <= CNT_W'(SCALED_W);
      end else if (busy) begin
         count_ff <= count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff   <= dividend;
         first_ff <= 1'b1;
      end else if (busy) begin
         rem_ff   <= take ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
         quo_ff   <= {quo_ff[SCALED_W-2:0], take};
         first_ff <= 1'b0;
      end
   end

endmodule

[rtl/mmfs_datapath.sv]
// ----------------------------------------------------------------------------
// Min-max feature scaler datapath
// Item register, column statistics, range checks, divider and output stage.
// ----------------------------------------------------------------------------
module mmfs_datapath import mmfs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  req_cmd,
   input  logic [COLUMN_W-1:0]      req_column,
   input  logic signed [DATA_W-1:0] req_sample_value,
   input  dp_cmd_type               dp_cmd,
   output dp_status_type            dp_status,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [SCALED_W-1:0]      rsp_scaled_value,
   output status_type               rsp_status
);

   cmd_type                  cmd_ff;
   logic [COLUMN_W-1:0]      column_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic [NUM_COLUMNS-1:0]   seen_ff;
   logic [2*DATA_W-1:0]      stat_rd_data;
   logic [2*DATA_W-1:0]      stat_wr_data;
   logic signed [DATA_W-1:0] col_lo;
   logic signed [DATA_W-1:0] col_hi;
   logic signed [DATA_W-1:0] new_lo;
   logic signed [DATA_W-1:0] new_hi;
   logic [COL_IDX_W-1:0]     col_idx;
   logic                     col_valid;
   logic                     col_seen;
   logic [DATA_W:0]          offset_ff;
   logic [DATA_W:0]          range_ff;
   logic                     is_zero;
   logic                     is_below;
   logic                     is_above;
   logic                     early;
   logic                     res_fast_ff;
   status_type               res_status_ff;
   logic [SCALED_W-1:0]      res_value_ff;
   logic [SCALED_W-1:0]      quotient;
   logic                     div_done;
   logic                     rsp_valid_ff;
   logic [SCALED_W-1:0]      rsp_value_ff;
   status_type               rsp_status_ff;

   always_ff @(posedge clock) begin
      if (dp_cmd.load_item) begin
         cmd_ff    <= req_cmd;
         column_ff <= req_column;
         value_ff  <= req_sample_value;
      end
   end

   assign col_valid = (int'(column_ff) < NUM_COLUMNS);
   assign col_idx   = COL_IDX_W'(column_ff);
   assign col_seen  = col_valid && seen_ff[col_idx];

   always_ff @(posedge clock) begin
      if (reset || dp_cmd.seen_clear) begin
         seen_ff <= '0;
      end else if (dp_cmd.obs_write && col_valid) begin
         seen_ff[col_idx] <= 1'b1;
      end
   end

   // Minimum in the upper half of a word, maximum in the lower half.
   mmfs_ram #(
      .WIDTH (2 * DATA_W),
      .DEPTH (NUM_COLUMNS)
   ) u_stat_ram (
      .clock      (clock),
      .wr_en      (dp_cmd.obs_write && col_valid),
      .wr_addr    (col_idx),
      .wr_data    (stat_wr_data),
      .rd_addr    (col_idx),
      .rd_data_ff (stat_rd_data)
   );

   assign col_lo = stat_rd_data[2*DATA_W-1:DATA_W];
   assign col_hi = stat_rd_data[DATA_W-1:0];

   // The first sample of a column sets both bounds, whatever the stale entry holds.
   assign new_lo = (!col_seen || (value_ff < col_lo)) ? value_ff : col_lo;
   assign new_hi = (!col_seen || (value_ff > col_hi)) ? value_ff : col_hi;
   assign stat_wr_data = {new_lo, new_hi};

   always_ff @(posedge clock) begin
      if (dp_cmd.diff_load) begin
         offset_ff <= {value_ff[DATA_W-1], value_ff} - {col_lo[DATA_W-1], col_lo};
         range_ff  <= {col_hi[DATA_W-1], col_hi} - {col_lo[DATA_W-1], col_lo};
      end
   end

   // The range is never negative once the column has been seen, so its top
   // bit is clear and the offset's sign bit marks a value below the minimum.
   assign is_zero  = (range_ff == '0);
   assign is_below = offset_ff[DATA_W];
   assign is_above = (offset_ff[DATA_W-1:0] > range_ff[DATA_W-1:0]);
   assign early    = !col_seen || is_zero || is_below || is_above;

   always_ff @(posedge clock) begin
      if (dp_cmd.check_load) begin
         res_fast_ff <= early;
         if (!col_seen) begin
            res_status_ff <= ST_UNSEEN;
            res_value_ff  <= '0;
         end else if (is_zero) begin
            res_status_ff <= ST_ZERO_RANGE;
            res_value_ff  <= '0;
         end else if (is_below) begin
            res_status_ff <= ST_CLAMPED;
            res_value_ff  <= '0;
         end else if (is_above) begin
            res_status_ff <= ST_CLAMPED;
            res_value_ff  <= Q_ONE;
         end else begin
            res_status_ff <= ST_OK;
            res_value_ff  <= '0;
         end
      end
   end

   mmfs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (dp_cmd.div_start),
      .dividend (offset_ff[DATA_W-1:0]),
      .divisor  (range_ff[DATA_W-1:0]),
      .quotient (quotient),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.out_load) begin
         rsp_value_ff  <= res_fast_ff ? res_value_ff : quotient;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scaled_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

   assign dp_status.cmd          = cmd_ff;
   assign dp_status.early_result = early;
   assign dp_status.div_done     = div_done;
   assign dp_status.out_free     = !rsp_valid_ff || rsp_ready;

endmodule

[rtl/mmfs_ctrl.sv]
// ----------------------------------------------------------------------------
// Min-max feature scaler controller
// Sequences one item at a time: statistics read, then a clear, an update, or
// checks, division and hand-over to the output register.
// ----------------------------------------------------------------------------
module mmfs_ctrl import mmfs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_EVAL  = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      dp_cmd    = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.load_item = 1'b1;
               state_in         = S_READ;
            end
         end
         // The statistics word is read during this cycle.
         S_READ: begin
            unique case (dp_status.cmd) inside
               CMD_OBSERVE, CMD_SCALE: begin
                  state_in = S_EVAL;
               end
               CMD_CLEAR: begin
                  dp_cmd.seen_clear = 1'b1;
                  state_in          = S_IDLE;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_EVAL: begin
            if (dp_status.cmd == CMD_OBSERVE) begin
               dp_cmd.obs_write = 1'b1;
               state_in         = S_IDLE;
            end else begin
               dp_cmd.diff_load = 1'b1;
               state_in         = S_CHECK;
            end
         end
         S_CHECK: begin
            dp_cmd.check_load = 1'b1;
            if (dp_status.early_result) begin
               state_in = S_OUT;
            end else begin
               dp_cmd.div_start = 1'b1;
               state_in         = S_DIV;
            end
         end
         S_DIV: begin
            if (dp_status.div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (dp_status.out_free) begin
               dp_cmd.out_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[rtl/min_max_feature_scaler_top.sv]
// ----------------------------------------------------------------------------
// Min-max feature scaler
// Tracks per-column minimum and maximum and scales values into Q1.16.
// ----------------------------------------------------------------------------
// Sequence: an observe passes read and update states before the next item is taken,
// a clear only the read state. A scale passes the read, difference and check states;
// a divided one waits in the divide state for the 17 steps of the radix-2 divider.
// The result enters the output register once that is free. Throughput: one item
// at a time. Reset clears the controller, the output register and every column's
// seen bit at once; the statistics memory needs no clearing pass.
module min_max_feature_scaler_top import mmfs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mmfs_req_if.sink  req_if,
   mmfs_rsp_if.source rsp_if
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   mmfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   mmfs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req_if.cmd),
      .req_column       (req_if.column),
      .req_sample_value (req_if.sample_value),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .rsp_ready        (rsp_if.ready),
      .rsp_valid        (rsp_if.valid),
      .rsp_scaled_value (rsp_if.scaled_value),
      .rsp_status       (rsp_if.status)
   );

   // A result is only moved into the output register when the slot is free.
   assert property (@(posedge clock) disable iff (reset)
      dp_cmd.out_load |-> dp_status.out_free)
      else $error("result loaded over an untaken response");

   assert property (@(posedge clock) disable iff (reset)
      dp_cmd.out_load |=> rsp_if.valid)
      else $error("loaded result not presented");

   // The item register is loaded only on an input transfer.
   assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load_item |-> (req_if.valid && req_if.ready))
      else $error("item register loaded without a transfer");

   assert property (@(posedge clock) disable iff (reset)
      dp_cmd.div_start |=> !req_if.ready)
      else $error("new item accepted while division runs");

endmodule

[tb/sv/min_max_feature_scaler_top_tb.sv]
// ----------------------------------------------------------------------------
// Min-max feature scaler testbench
// Streams observe, scale, clear and unused commands through the scaler with
// random gaps and stalls on both channels. Every scale transfer is predicted
// from a local copy of the column statistics, and each response is checked
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module min_max_feature_scaler_top_tb;
   import mmfs_pkg::*;

   localparam cmd_type CMD_UNUSED   = 2'd3;
   localparam int      CYCLE_LIMIT  = 400000;
   localparam int      DRAIN_CYCLES = 40;
   localparam int      ITEM_TARGET  = 1400;
   localparam int      REPORT_LIMIT = 10;

   typedef struct packed {
      logic [SCALED_W-1:0] scaled_value;
      status_type          status;
   } scaled_result_type;

   logic clock;
   logic reset;

   mmfs_req_if req_ch ();
   mmfs_rsp_if rsp_ch ();

   min_max_feature_scaler_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Local copy of the per-column statistics.
   logic signed [DATA_W-1:0] track_min [NUM_COLUMNS];
   logic signed [DATA_W-1:0] track_max [NUM_COLUMNS];
   bit                       col_observed [NUM_COLUMNS];

   scaled_result_type expected_scaled [$];

   int unsigned req_gap_max;
   int unsigned rsp_stall_max;
   int unsigned items_sent;
   int unsigned mismatch_count;
   int unsigned cycle_count;

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic scaled_result_type predict_scaled(logic [COLUMN_W-1:0] column,
                                                        logic signed [DATA_W-1:0] value);
      scaled_result_type res;
      longint            lo;
      longint            hi;
      longint            v;
      longint unsigned   span;
      longint unsigned   offset;
      res.scaled_value = '0;
      res.status       = ST_OK;
      if (column >= NUM_COLUMNS || !col_observed[column]) begin
         res.status = ST_UNSEEN;
         return res;
      end
      lo = track_min[column];
      hi = track_max[column];
      v  = value;
      // A flat column is reported before any clamping is considered.
      if (hi == lo) begin
         res.status = ST_ZERO_RANGE;
      end else if (v < lo) begin
         res.status = ST_CLAMPED;
      end else if (v > hi) begin
         res.status       = ST_CLAMPED;
         res.scaled_value = Q_ONE;
      end else begin
         span             = hi - lo;
         offset           = v - lo;
         res.scaled_value = SCALED_W'((offset << FRAC_W) / span);
      end
      return res;
   endfunction

   task automatic send_item(cmd_type cmd, logic [COLUMN_W-1:0] column,
                            logic signed [DATA_W-1:0] value);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.cmd          <= cmd;
      req_ch.column       <= column;
      req_ch.sample_value <= value;
      do @(posedge clock); while (!req_ch.ready);
      // The transfer has happened: update the local statistics accordingly.
      case (cmd)
         CMD_OBSERVE: begin
            if (column < NUM_COLUMNS) begin
               if (!col_observed[column]) begin
                  track_min[column]    = value;
                  track_max[column]    = value;
                  col_observed[column] = 1'b1;
               end else begin
                  if (value < track_min[column]) track_min[column] = value;
                  if (value > track_max[column]) track_max[column] = value;
               end
            end
         end
         CMD_SCALE: begin
            expected_scaled.insert(expected_scaled.size(), predict_scaled(column, value));
         end
         CMD_CLEAR: begin
            foreach (col_observed[i]) col_observed[i] = 1'b0;
         end
         default: begin
         end
      endcase
      if (cmd != CMD_UNUSED) items_sent++;
   endtask

   // Always waits on the clock before it returns, so valid is never lowered
   // and raised in the same time step.
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_scaled.size() > 0);
   endtask

   initial begin
      int unsigned       stall;
      scaled_result_type got;
      scaled_result_type want;
      rsp_ch.ready = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got.scaled_value = rsp_ch.scaled_value;
         got.status       = rsp_ch.status;
         if (expected_scaled.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("tb: unexpected response: value %0d status %0d",
                        got.scaled_value, got.status);
         end else begin
            want = expected_scaled.pop_front();
            if (got.scaled_value !== want.scaled_value || got.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"tb: response mismatch: expected value %0d status %0d, ",
                            "got value %0d status %0d"},
                           want.scaled_value, want.status, got.scaled_value, got.status);
            end
         end
      end
   end

   task automatic test_special_cases();
      send_item(CMD_CLEAR, 6'd0, 0);
      send_item(CMD_SCALE, 6'd5, 0);
      send_item(CMD_OBSERVE, 6'd0, 32'sh8000_0000);
      // A flat column wins over a value far outside it.
      send_item(CMD_SCALE, 6'd0, 32'sh7FFF_FFFF);
      send_item(CMD_OBSERVE, 6'd0, 32'sh7FFF_FFFF);
      send_item(CMD_SCALE, 6'd0, 32'sh8000_0000);
      send_item(CMD_SCALE, 6'd0, 32'sh7FFF_FFFF);
      send_item(CMD_SCALE, 6'd0, 0);
      send_item(CMD_SCALE, 6'd0, -1);
      send_item(CMD_OBSERVE, 6'd63, 100);
      send_item(CMD_SCALE, 6'd63, 50);
      send_item(CMD_OBSERVE, 6'd63, 200);
      send_item(CMD_OBSERVE, 6'd63, 150);
      send_item(CMD_SCALE, 6'd63, 99);
      send_item(CMD_SCALE, 6'd63, 201);
      send_item(CMD_SCALE, 6'd63, 150);
      send_item(CMD_SCALE, 6'd63, 199);
      send_item(CMD_UNUSED, 6'd63, -1);
      send_item(CMD_CLEAR, 6'd63, -1);
      send_item(CMD_SCALE, 6'd0, 0);
      send_item(CMD_SCALE, 6'd63, 150);
      wait_for_results();
   endtask

   // Well-formed two-pass sequences: an observe pass over a few columns, then
   // a scale pass mostly inside the observed range.
   task automatic test_dataset_passes();
      logic [COLUMN_W-1:0]      cols [8];
      logic signed [DATA_W-1:0] centre;
      logic signed [DATA_W-1:0] value;
      logic [COLUMN_W-1:0]      column;
      int unsigned              n_cols;
      int unsigned              spread;
      int unsigned              pick;
      int unsigned              round;
      round = 0;
      while (items_sent < ITEM_TARGET - 200) begin
         req_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 10;
         rsp_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
         n_cols = $urandom_range(1, 8);
         for (int i = 0; i < 8; i++) cols[i] = COLUMN_W'($urandom_range(0, NUM_COLUMNS - 1));
         case ($urandom_range(0, 3))
            0: spread = 0;
            1: spread = $urandom_range(1, 16);
            2: spread = $urandom_range(1, 1 << 20);
            default: spread = 32'hFFFF_FFFF;
         endcase
         centre = $urandom;
         repeat ($urandom_range(1, 12)) begin
            value = centre + $urandom_range(0, spread);
            send_item(CMD_OBSERVE, cols[$urandom_range(0, n_cols - 1)], value);
         end
         repeat ($urandom_range(4, 16)) begin
            pick   = $urandom_range(0, 9);
            column = cols[$urandom_range(0, n_cols - 1)];
            value  = centre + $urandom_range(0, spread);
            if (pick == 6) value = centre - $urandom_range(1, 4);
            if (pick == 7) value = centre + spread + $urandom_range(1, 4);
            if (pick == 8) value = $urandom;
            if (pick == 9) column = COLUMN_W'($urandom_range(0, NUM_COLUMNS - 1));
            send_item(CMD_SCALE, column, value);
         end
         if ($urandom_range(0, 5) == 0) send_item(CMD_UNUSED, COLUMN_W'($urandom), $urandom);
         if ($urandom_range(0, 3) == 0) send_item(CMD_CLEAR, COLUMN_W'($urandom), $urandom);
         if (round % 8 == 0) wait_for_results();
         round++;
      end
   endtask

   task automatic test_noise_items();
      req_gap_max   = 10;
      rsp_stall_max = 10;
      while (items_sent < ITEM_TARGET)
         send_item(cmd_type'($urandom_range(0, 3)), COLUMN_W'($urandom), $urandom);
   endtask

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.cmd          = CMD_OBSERVE;
      req_ch.column       = '0;
      req_ch.sample_value = '0;
      req_gap_max         = 10;
      rsp_stall_max       = 10;
      items_sent          = 0;
      mismatch_count      = 0;
      cycle_count         = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_special_cases();
      test_dataset_passes();
      test_noise_items();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
